// ===== hw/rtl/risas_pkg.sv =====
// shared types and constants for the record index sort and search block
package risas_pkg;
  localparam int MaxRecords = 64;
  localparam int KeyBytes = 8;
  localparam int SlotW = $clog2(MaxRecords);
  localparam int CountW = $clog2(MaxRecords + 1);
  localparam int KeyW = 64;
  localparam int CourseW = 3;
  localparam int GradeW = 7;
  localparam int RecW = KeyW + CourseW + GradeW;
  localparam logic [GradeW-1:0] GradeMax = 7'd100;
  localparam logic [KeyW-1:0] KeyMask =
    (KeyBytes >= 8) ? {KeyW{1'b1}} : ((64'd1 << (8 * KeyBytes)) - 64'd1);

  localparam logic [1:0] ActLoad = 2'd0;
  localparam logic [1:0] ActSort = 2'd1;
  localparam logic [1:0] ActSearch = 2'd2;

  typedef struct packed {
    logic [GradeW-1:0] grade;
    logic [CourseW-1:0] course;
    logic [KeyW-1:0] key;
  } rec_t;

  // true when a must stand strictly before b
  function automatic logic goes_before(rec_t a, rec_t b);
    if (a.grade != b.grade) return a.grade > b.grade;
    if (a.course != b.course) return a.course < b.course;
    return a.key < b.key;
  endfunction
endpackage

// ===== hw/rtl/record_index_sort_and_search.sv =====
// top level: record table, insertion sort of the index order and binary search
//  channel | direction | handshake      | payload
//  in      | input     | valid / stall  | action slot surname_key course profile_grade
//  out     | output    | valid / stall  | found found_slot done_res
//  cfg     | input     | valid / ready  | data (record_count)
// load writes the record into its slot. sort fills the order ram slot by slot, then does a
// record fetch per entry plus a shift step per move in the insertion pass (one order ram port,
// one record ram port). search: up to log2(n)+1 probes.
// reset is synchronous; it clears control and record_count, not the rams.
// input stalls while an item is at work or its result waits; out holds when stalled.
module record_index_sort_and_search (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    action,
  input  logic [risas_pkg::SlotW-1:0]   slot,
  input  logic [risas_pkg::KeyW-1:0]    surname_key,
  input  logic [risas_pkg::CourseW-1:0] course,
  input  logic [risas_pkg::GradeW-1:0]  profile_grade,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [risas_pkg::CountW-1:0]  data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          found,
  output logic [risas_pkg::SlotW-1:0]   found_slot,
  output logic                          done_res
);
  import risas_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FILL  = 4'd1;
  localparam logic [3:0] S_OUTER = 4'd2;
  localparam logic [3:0] S_CUR0  = 4'd3;
  localparam logic [3:0] S_CUR1  = 4'd4;
  localparam logic [3:0] S_PRV0  = 4'd5;
  localparam logic [3:0] S_PRV1  = 4'd6;
  localparam logic [3:0] S_CMP   = 4'd7;
  localparam logic [3:0] S_SPRB  = 4'd8;
  localparam logic [3:0] S_SIDX  = 4'd9;
  localparam logic [3:0] S_SREC  = 4'd10;
  localparam logic [3:0] S_SCMP  = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;
  localparam logic [3:0] S_PRVW  = 4'd13;
  localparam logic [3:0] S_CURW  = 4'd14;

  logic [3:0] state;
  logic [CountW-1:0] record_count, n, i, j, lo, hi;
  logic [CountW-1:0] mid;
  rec_t tgt, cur_rec;
  logic [SlotW-1:0] cur_idx, prv_idx;

  logic ord_we, rec_we;
  logic [SlotW-1:0] ord_addr, ord_wdata, ord_rdata, rec_addr;
  rec_t rec_wdata, rec_rdata;

  risas_ram #(.Width(SlotW), .Depth(MaxRecords)) u_order (
    .clk, .we(ord_we), .addr(ord_addr), .wdata(ord_wdata), .rdata(ord_rdata));
  risas_ram #(.Width(RecW), .Depth(MaxRecords)) u_rec (
    .clk, .we(rec_we), .addr(rec_addr), .wdata(rec_wdata), .rdata(rec_rdata));

  assign cfg_ready = (state == S_IDLE) && !out_valid;
  assign in_stall = (state != S_IDLE) || out_valid;
  logic in_acc;
  assign in_acc = in_valid && !in_stall;
  assign mid = lo + ((hi - lo) >> 1);

  logic [GradeW-1:0] sat_g;
  assign sat_g = (profile_grade > GradeMax) ? GradeMax : profile_grade;
  logic [CountW-1:0] cnt_sat;
  assign cnt_sat = (record_count > CountW'(MaxRecords)) ? CountW'(MaxRecords) : record_count;

  logic hit, go_hi;
  assign hit = rec_rdata == tgt;
  assign go_hi = (rec_rdata.grade < tgt.grade) ||
                 (rec_rdata.grade == tgt.grade && rec_rdata.course > tgt.course) ||
                 (rec_rdata.grade == tgt.grade && rec_rdata.course == tgt.course &&
                  rec_rdata.key > tgt.key);

  always_comb begin
    ord_we = 1'b0;
    ord_addr = i[SlotW-1:0];
    ord_wdata = i[SlotW-1:0];
    rec_we = 1'b0;
    rec_addr = ord_rdata;
    rec_wdata = '{grade: sat_g, course: course, key: surname_key & KeyMask};
    unique case (state)
      S_IDLE: begin
        rec_we = in_acc && action == ActLoad;
        rec_addr = slot;
      end
      S_FILL: ord_we = 1'b1;
      S_OUTER, S_CUR0: ord_addr = i[SlotW-1:0];
      S_PRV0: ord_addr = SlotW'(j - 1'b1);
      S_CMP: begin
        ord_addr = j[SlotW-1:0];
        ord_we = 1'b1;
        ord_wdata = (j != 0 && goes_before(cur_rec, rec_rdata)) ? prv_idx : cur_idx;
      end
      S_SPRB: ord_addr = mid[SlotW-1:0];
      default: begin
        ord_addr = mid[SlotW-1:0];
      end
    endcase
    if (state == S_CUR1 || state == S_CURW) rec_addr = ord_rdata;
    if (state == S_PRV1 || state == S_SIDX) rec_addr = ord_rdata;
    if (state == S_PRVW) rec_addr = prv_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      record_count <= '0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cfg_valid && cfg_ready) record_count <= data;
      unique case (state)
        S_IDLE: if (in_acc) begin
          tgt <= '{grade: sat_g, course: course, key: surname_key & KeyMask};
          n <= cnt_sat; i <= '0; lo <= '0; hi <= cnt_sat;
          found <= 1'b0; found_slot <= '0;
          done_res <= (action == ActLoad) || (action == ActSort) || (action == ActSearch);
          if (action == ActSort) state <= (cnt_sat == 0) ? S_DONE : S_FILL;
          else if (action == ActSearch) state <= S_SPRB;
          else state <= S_DONE;
        end
        S_FILL: begin
          if (i + 1'b1 >= n) begin i <= CountW'(1); state <= S_OUTER; end
          else i <= i + 1'b1;
        end
        S_OUTER: begin
          if (i >= n) state <= S_DONE;
          else begin j <= i; state <= S_CUR0; end
        end
        S_CUR0: state <= S_CUR1;
        S_CUR1: begin cur_idx <= ord_rdata; state <= S_CURW; end
        S_CURW: begin cur_rec <= rec_rdata; state <= S_PRV0; end
        S_PRV0: state <= S_PRV1;
        S_PRV1: begin prv_idx <= ord_rdata; state <= S_PRVW; end
        S_PRVW: state <= S_CMP;
        S_CMP: begin
          if (j != 0 && goes_before(cur_rec, rec_rdata)) begin
            j <= j - 1'b1;
            state <= (j > 1) ? S_PRV0 : S_CMP;
          end else begin
            i <= i + 1'b1; state <= S_OUTER;
          end
        end
        S_SPRB: state <= (lo < hi) ? S_SIDX : S_DONE;
        S_SIDX: state <= S_SREC;
        S_SREC: state <= S_SCMP;
        S_SCMP: begin
          if (hit) begin
            found <= 1'b1; found_slot <= ord_rdata; state <= S_DONE;
          end else begin
            if (go_hi) hi <= mid; else lo <= mid + 1'b1;
            state <= S_SPRB;
          end
        end
        S_DONE: if (!out_valid) begin out_valid <= 1'b1; state <= S_IDLE; end
        default: state <= S_IDLE;
      endcase
    end
  end

  // in S_CMP with j at zero the pass writes cur into the first entry

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_acc) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("result dropped");
  a_found_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> done_res) else $error("found without done");
  a_search_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_SIDX) |-> (lo < hi && hi <= CountW'(MaxRecords))) else $error("probe range");
endmodule

// ===== hw/rtl/risas_ram.sv =====
// generic single port ram with registered read
module risas_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ===== tb/sv/record_index_sort_and_search_tb.sv =====
// testbench for record_index_sort_and_search: directed table, then random checked items
module record_index_sort_and_search_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import risas_pkg::*;

  localparam logic [1:0] ActNone = 2'd3;

  typedef struct {
    bit               is_cfg;
    logic [1:0]       act;
    logic [SlotW-1:0] slt;
    logic [KeyW-1:0]  key;
    logic [CourseW-1:0] crs;
    logic [GradeW-1:0]  grd;
    bit               typed;
    logic             t_found;
    logic [SlotW-1:0] t_slot;
    logic             t_done;
  } row_t;

  typedef struct {
    logic             hit;
    logic [SlotW-1:0] hit_slot;
    logic             ack;
  } answer_t;

  logic clk, rst;
  logic in_valid, in_stall;
  logic [1:0] action;
  logic [SlotW-1:0] slot;
  logic [KeyW-1:0] surname_key;
  logic [CourseW-1:0] course;
  logic [GradeW-1:0] profile_grade;
  logic cfg_valid, cfg_ready;
  logic [CountW-1:0] data;
  logic out_valid, out_stall;
  logic found;
  logic [SlotW-1:0] found_slot;
  logic done_res;

  record_index_sort_and_search uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .slot(slot), .surname_key(surname_key),
    .course(course), .profile_grade(profile_grade),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .data(data),
    .out_valid(out_valid), .out_stall(out_stall),
    .found(found), .found_slot(found_slot), .done_res(done_res)
  );

  // predictor state
  logic [KeyW-1:0]    key_mem [MaxRecords];
  logic [CourseW-1:0] crs_mem [MaxRecords];
  logic [GradeW-1:0]  grd_mem [MaxRecords];
  logic [SlotW-1:0]   order_mem [MaxRecords];
  bit rec_written [MaxRecords];
  bit ord_written [MaxRecords];
  int unsigned live_count;

  answer_t pending_answers[$];
  int errors = 0;
  int stall_mode;
  logic [KeyW-1:0] key_pool [6];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Regression FAIL");
    $finish;
  end

  function automatic int unsigned active_n();
    return (live_count > MaxRecords) ? MaxRecords : live_count;
  endfunction

  function automatic logic [GradeW-1:0] clip_grade(logic [GradeW-1:0] g);
    return (g > GradeMax) ? GradeMax : g;
  endfunction

  function automatic bit ranks_ahead(int a, int b);
    if (grd_mem[a] != grd_mem[b]) return grd_mem[a] > grd_mem[b];
    if (crs_mem[a] != crs_mem[b]) return crs_mem[a] < crs_mem[b];
    return key_mem[a] < key_mem[b];
  endfunction

  // index order: grade down, course up, surname up, stable
  function automatic void rebuild_order();
    int n, j;
    logic [SlotW-1:0] cur;
    n = active_n();
    for (int i = 0; i < n; i++) begin
      order_mem[i] = SlotW'(i);
      ord_written[i] = 1'b1;
    end
    for (int i = 1; i < n; i++) begin
      cur = order_mem[i];
      j = i;
      while (j > 0 && ranks_ahead(cur, order_mem[j-1])) begin
        order_mem[j] = order_mem[j-1];
        j--;
      end
      order_mem[j] = cur;
    end
  endfunction

  function automatic answer_t lookup_record(logic [KeyW-1:0] k, logic [CourseW-1:0] c,
                                            logic [GradeW-1:0] g);
    answer_t r;
    int lo, hi, mid, idx;
    r = '{hit: 1'b0, hit_slot: '0, ack: 1'b1};
    lo = 0;
    hi = active_n();
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      idx = order_mem[mid];
      if (key_mem[idx] == k && crs_mem[idx] == c && grd_mem[idx] == g) begin
        r.hit = 1'b1;
        r.hit_slot = SlotW'(idx);
        return r;
      end
      if (grd_mem[idx] < g || (grd_mem[idx] == g && crs_mem[idx] > c) ||
          (grd_mem[idx] == g && crs_mem[idx] == c && key_mem[idx] > k))
        hi = mid;
      else
        lo = mid + 1;
    end
    return r;
  endfunction

  function automatic answer_t predict_item(logic [1:0] a, logic [SlotW-1:0] s,
                                           logic [KeyW-1:0] k, logic [CourseW-1:0] c,
                                           logic [GradeW-1:0] g);
    answer_t r;
    r = '{hit: 1'b0, hit_slot: '0, ack: 1'b1};
    case (a)
      ActLoad: begin
        key_mem[s] = k & KeyMask;
        crs_mem[s] = c;
        grd_mem[s] = clip_grade(g);
        rec_written[s] = 1'b1;
      end
      ActSort: rebuild_order();
      ActSearch: r = lookup_record(k & KeyMask, c, clip_grade(g));
      default: r.ack = 1'b0;
    endcase
    return r;
  endfunction

  // first slot read before written, MaxRecords for an order gap, -1 if none
  function automatic int first_gap(logic [1:0] a);
    int n;
    n = active_n();
    for (int i = 0; i < n; i++) begin
      if (!rec_written[i]) return i;
      if (a == ActSearch && !ord_written[i]) return MaxRecords;
    end
    return -1;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 65) return 0;
    if (p < 95) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if ($urandom_range(199) == 0) stall_mode <= $urandom_range(2);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(3) == 0);
        default: out_stall <= ($urandom_range(9) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    answer_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_answers.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result found=%0d slot=%0d done=%0d",
                                   found, found_slot, done_res);
      end else begin
        e = pending_answers.pop_front();
        if (found !== e.hit || found_slot !== e.hit_slot || done_res !== e.ack) begin
          errors++;
          if (errors <= 10)
            $display("mismatch exp found=%0d slot=%0d done=%0d got found=%0d slot=%0d done=%0d",
                     e.hit, e.hit_slot, e.ack, found, found_slot, done_res);
        end
      end
    end
  end

  task automatic send_item(logic [1:0] a, logic [SlotW-1:0] s, logic [KeyW-1:0] k,
                           logic [CourseW-1:0] c, logic [GradeW-1:0] g,
                           bit typed, answer_t t);
    answer_t p;
    int gap;
    in_valid <= 1'b1;
    action <= a;
    slot <= s;
    surname_key <= k;
    course <= c;
    profile_grade <= g;
    do @(posedge clk); while (in_stall);
    p = predict_item(a, s, k, c, g);
    pending_answers.push_back(typed ? t : p);
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_count(logic [CountW-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    data <= v;
    do @(posedge clk); while (!cfg_ready);
    live_count = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic random_item();
    logic [1:0] a;
    logic [SlotW-1:0] s;
    logic [KeyW-1:0] k;
    logic [CourseW-1:0] c;
    logic [GradeW-1:0] g;
    int n, p, gapslot, src;
    n = active_n();
    p = $urandom_range(99);
    a = (p < 55) ? ActLoad : (p < 62) ? ActSort : (p < 97) ? ActSearch : ActNone;
    s = (n > 0 && $urandom_range(3) != 0) ? SlotW'($urandom_range(n - 1))
                                           : SlotW'($urandom_range(63));
    k = ($urandom_range(1) == 0) ? key_pool[$urandom_range(5)] : {$urandom, $urandom};
    c = CourseW'($urandom_range(7));
    g = ($urandom_range(2) == 0) ? GradeW'($urandom_range(127))
                                 : GradeW'(40 + $urandom_range(3));
    if (a == ActSearch && n > 0 && $urandom_range(9) < 6) begin
      src = $urandom_range(n - 1);
      if (rec_written[src]) begin
        k = key_mem[src];
        c = crs_mem[src];
        g = grd_mem[src];
      end
    end
    if (a == ActSort || a == ActSearch) begin
      gapslot = first_gap(a);
      if (gapslot >= MaxRecords) begin
        if (first_gap(ActSort) < 0) a = ActSort;
        else begin
          a = ActLoad;
          s = SlotW'(first_gap(ActSort));
        end
      end else if (gapslot >= 0) begin
        a = ActLoad;
        s = SlotW'(gapslot);
      end
    end
    send_item(a, s, k, c, g, 1'b0, '{hit: 1'b0, hit_slot: '0, ack: 1'b0});
  endtask

  row_t steps [] = '{
    '{1, ActLoad, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, ActLoad, 0, 64'hFFFF_FFFF_FFFF_FFFF, 7, 127, 1, 0, 0, 1},
    '{0, ActNone, 63, 64'h5A5A_0000_FFFF_1234, 5, 9, 1, 0, 0, 0},
    '{0, ActSearch, 0, 0, 0, 0, 1, 0, 0, 1},
    '{0, ActSort, 0, 0, 0, 0, 1, 0, 0, 1},
    '{0, ActLoad, 63, 0, 0, 0, 1, 0, 0, 1},
    '{0, ActLoad, 1, 64'h8000_0000_0000_0000, 0, 100, 1, 0, 0, 1},
    '{0, ActLoad, 2, 64'h0000_0000_0000_0001, 3, 101, 1, 0, 0, 1},
    '{0, ActLoad, 3, 64'h414C_4943_4500_0000, 2, 55, 1, 0, 0, 1},
    '{1, ActLoad, 4, 0, 0, 0, 0, 0, 0, 0},
    '{0, ActSort, 0, 0, 0, 0, 1, 0, 0, 1},
    '{0, ActSearch, 0, 64'hFFFF_FFFF_FFFF_FFFF, 7, 127, 0, 0, 0, 0},
    '{0, ActSearch, 0, 64'h8000_0000_0000_0000, 0, 100, 0, 0, 0, 0},
    '{0, ActSearch, 0, 64'h0000_0000_0000_0001, 3, 100, 0, 0, 0, 0},
    '{0, ActSearch, 0, 64'h414C_4943_4500_0000, 2, 55, 0, 0, 0, 0},
    '{0, ActSearch, 0, 64'h414C_4943_4500_0001, 2, 55, 0, 0, 0, 0},
    '{0, ActSearch, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, ActLoad, 3, 64'h8000_0000_0000_0000, 0, 100, 1, 0, 0, 1},
    '{0, ActSearch, 0, 64'h8000_0000_0000_0000, 0, 100, 0, 0, 0, 0},
    '{0, ActSort, 0, 0, 0, 0, 1, 0, 0, 1},
    '{0, ActSearch, 0, 64'h8000_0000_0000_0000, 0, 100, 0, 0, 0, 0}
  };

  initial begin
    int phase_items, cnt;
    rst = 1'b1;
    in_valid = 1'b0;
    action = ActLoad;
    slot = '0;
    surname_key = '0;
    course = '0;
    profile_grade = '0;
    cfg_valid = 1'b0;
    data = '0;
    live_count = 0;
    for (int i = 0; i < MaxRecords; i++) begin
      rec_written[i] = 1'b0;
      ord_written[i] = 1'b0;
    end
    for (int i = 0; i < 6; i++) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (steps[i]) begin
      if (steps[i].is_cfg)
        write_count(CountW'(steps[i].slt));
      else
        send_item(steps[i].act, steps[i].slt, steps[i].key, steps[i].crs, steps[i].grd,
                  steps[i].typed, '{hit: steps[i].t_found, hit_slot: steps[i].t_slot,
                                    ack: steps[i].t_done});
    end

    for (int ph = 0; ph < 18; ph++) begin
      case (ph)
        2, 9: cnt = MaxRecords;
        4: cnt = 127;
        6: cnt = 0;
        8: cnt = 1;
        12: cnt = 65;
        default: cnt = $urandom_range(16, 2);
      endcase
      write_count(CountW'(cnt));
      phase_items = (cnt >= MaxRecords) ? 150 : 90;
      for (int i = 0; i < phase_items; i++) begin
        random_item();
        if (i == phase_items / 2 && ph == 5) drain();
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule
